/* hw/rtl/sae_pkg.sv */
// Package: shared types, codes and widths of the stack allocator engine.
`default_nettype none
package sae_pkg;

  localparam int ARENA_BYTES_DEF    = 65536;
  localparam int MAX_ALIGN_LOG2_DEF = 12;
  localparam int HEADER_BYTES       = 8;
  localparam int HDR_SHIFT          = 3;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 17;
  localparam int ALIGN_W  = 4;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int HDR_W    = 2 * SIZE_W;
  localparam int UNIT_W   = 50;
  localparam int OFF_W    = 18;
  localparam int SZ_W     = 18;
  localparam int NOFF_W   = 19;
  localparam int AMASK_W  = 16;
  localparam int LG_W     = 5;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 88;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 64;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REALLOC = 2'd2;
  localparam logic [FUNC_W-1:0] FN_RESET   = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_OWNED = 2'd2;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_ARENA  = 2'd1;
  localparam logic [1:0] REG_DALIGN = 2'd2;

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_OWN_SUB = 16'h0002,
    ST_OWN_CHK = 16'h0004,
    ST_OWN_RD  = 16'h0008,
    ST_OWN_HDR = 16'h0010,
    ST_OWN_END = 16'h0020,
    ST_OWN_TST = 16'h0040,
    ST_SZ_ADD  = 16'h0080,
    ST_SZ_RND  = 16'h0100,
    ST_TOP     = 16'h0200,
    ST_ABS     = 16'h0400,
    ST_OFF     = 16'h0800,
    ST_RAD     = 16'h1000,
    ST_END     = 16'h2000,
    ST_CHK     = 16'h4000,
    ST_DONE    = 16'h8000
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/stack_allocator_engine.sv */
// Top level: stack arena allocator with a sequenced shared adder and a header memory.
//
//  channel | dir | handshake            | content
//  --------+-----+----------------------+---------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | func, block_address, request_size, align_log2
//  m_*     | out | m_tvalid / m_tready  | status, result_address, result_size,
//          |     |                      | copy_needed, used_bytes
//  apb     | in  | psel/penable/pready  | base_address, arena_size, default_align_log2
//
// One transfer at a time; each step but the header memory read is one add, subtract or
// compare on the shared 50-bit adder. Reset and null free go straight to the result.
// Reset (rst, synchronous) clears the stack top, the configuration registers and the
// output valid; the memory is not cleared. A stalled result is held in the output
// register while the sequencer waits.
`default_nettype none
module stack_allocator_engine #(
  parameter int ARENA_BYTES    = sae_pkg::ARENA_BYTES_DEF,
  parameter int MAX_ALIGN_LOG2 = sae_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // func[1:0], block_address[49:2], request_size[66:50], align_log2[70:67], pad
  input  logic [sae_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], result_address[49:2], result_size[66:50], copy_needed[67],
  // used_bytes[84:68], pad
  output logic [sae_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sae_pkg::PADDR_W-1:0]   paddr,
  input  logic [sae_pkg::PDATA_W-1:0]   pwdata,
  output logic [sae_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import sae_pkg::*;

  localparam int DEPTH = ARENA_BYTES / HEADER_BYTES;
  localparam int IDX_W = $clog2(DEPTH);

  state_t state;

  logic [ADDR_W-1:0]   base_address;
  logic [SIZE_W-1:0]   arena_size;
  logic [ALIGN_W-1:0]  default_align_log2;
  logic [SIZE_W-1:0]   stack_top;

  logic [FUNC_W-1:0]   func;
  logic [ADDR_W-1:0]   blk_addr;
  logic [SIZE_W-1:0]   req_size;
  logic [AMASK_W-1:0]  amask;
  logic [UNIT_W-1:0]   acc;
  logic [SZ_W-1:0]     sz;
  logic [OFF_W-1:0]    hdr_off;
  logic [NOFF_W-1:0]   noff;
  logic [HDR_W-1:0]    hdr;
  logic                blk_ge_base;
  logic                grow;
  logic                move;
  logic                rd_oor;

  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic [SIZE_W-1:0]   res_size;
  logic                res_copy;

  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_addr;
  logic [SIZE_W-1:0]   out_size;
  logic                out_copy;
  logic [SIZE_W-1:0]   out_used;

  logic [HDR_W-1:0]    hdr_mem [DEPTH];
  logic [HDR_W-1:0]    hdr_rdata;
  logic [HDR_W-1:0]    hdr_word;
  logic [HDR_W-1:0]    wr_data;
  logic [IDX_W-1:0]    mem_idx;
  logic                mem_we;
  logic                mem_re;
  logic                off_in_range;

  logic [FUNC_W-1:0]   in_func;
  logic [ADDR_W-1:0]   in_blk;
  logic [SIZE_W-1:0]   in_req;
  logic [ALIGN_W-1:0]  in_align;
  logic [ALIGN_W-1:0]  lg_max;
  logic [LG_W-1:0]     lg_eff;
  logic [AMASK_W-1:0]  amask_next;
  logic [SIZE_W-1:0]   arena_limit;
  logic [SIZE_W-1:0]   usize;
  logic                s_fire;
  logic                out_load;
  logic                cfg_we;

  logic [UNIT_W-1:0]   u_a;
  logic [UNIT_W-1:0]   u_b;
  logic                u_sub;
  logic                u_rnd;
  logic [UNIT_W:0]     u_sum;
  logic [UNIT_W-1:0]   u_res;
  logic                u_carry;

  assign in_func  = s_tdata[1:0];
  assign in_blk   = s_tdata[49:2];
  assign in_req   = s_tdata[66:50];
  assign in_align = s_tdata[70:67];

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign m_tdata  = {3'b000, out_used, out_copy, out_size, out_addr, out_status};

  // effective alignment
  assign lg_max     = (in_align > default_align_log2) ? in_align : default_align_log2;
  assign lg_eff     = (LG_W'(lg_max) > LG_W'(MAX_ALIGN_LOG2)) ? LG_W'(MAX_ALIGN_LOG2)
                                                              : LG_W'(lg_max);
  assign amask_next = AMASK_W'((32'(1) << lg_eff) - 32'(1));

  assign arena_limit = (32'(arena_size) > 32'(ARENA_BYTES)) ? SIZE_W'(ARENA_BYTES)
                                                             : arena_size;
  assign usize       = SIZE_W'(sz - SZ_W'(HEADER_BYTES));
  assign hdr_word    = rd_oor ? '0 : hdr_rdata;

  // shared adder
  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_sub = 1'b0;
    u_rnd = 1'b0;
    unique case (state)
      ST_OWN_SUB: begin
        u_a = UNIT_W'(blk_addr); u_b = UNIT_W'(base_address); u_sub = 1'b1;
      end
      ST_OWN_CHK: begin
        u_a = UNIT_W'(stack_top); u_b = acc; u_sub = 1'b1;
      end
      ST_OWN_HDR: begin
        u_a = UNIT_W'(hdr_word[SIZE_W-1:0]); u_b = UNIT_W'(req_size); u_sub = 1'b1;
      end
      ST_OWN_END: begin
        u_a = acc; u_b = UNIT_W'(hdr[SIZE_W-1:0]);
      end
      ST_OWN_TST: begin
        u_a = UNIT_W'(stack_top); u_b = acc; u_sub = 1'b1;
      end
      ST_SZ_ADD: begin
        u_a = UNIT_W'(req_size); u_b = UNIT_W'(HEADER_BYTES);
      end
      ST_SZ_RND: begin
        u_a = UNIT_W'(sz); u_b = UNIT_W'(amask); u_rnd = 1'b1;
      end
      ST_TOP: begin
        u_a = UNIT_W'(base_address); u_b = UNIT_W'(stack_top);
      end
      ST_ABS: begin
        u_a = acc; u_b = UNIT_W'(amask); u_rnd = 1'b1;
      end
      ST_OFF: begin
        u_a = acc; u_b = UNIT_W'(base_address); u_sub = 1'b1;
      end
      ST_RAD: begin
        u_a = acc; u_b = UNIT_W'(HEADER_BYTES);
      end
      ST_END: begin
        u_a = UNIT_W'(hdr_off); u_b = UNIT_W'(sz);
      end
      ST_CHK: begin
        u_a = UNIT_W'(arena_limit); u_b = UNIT_W'(noff); u_sub = 1'b1;
      end
      default: begin
        u_a = '0;
      end
    endcase
  end

  assign u_sum   = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + (UNIT_W + 1)'(u_sub);
  assign u_carry = u_sum[UNIT_W];
  assign u_res   = u_sum[UNIT_W-1:0] & ~(u_rnd ? UNIT_W'(amask) : UNIT_W'(0));

  // header memory
  assign off_in_range = (32'(hdr_off >> HDR_SHIFT) < DEPTH);
  assign mem_idx      = IDX_W'(hdr_off >> HDR_SHIFT);
  assign mem_re       = (state == ST_OWN_RD);
  assign mem_we       = (state == ST_CHK) && u_carry && off_in_range;
  assign wr_data      = {(grow ? hdr[HDR_W-1:SIZE_W] : stack_top), usize};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_idx] <= wr_data;
    end
    if (mem_re) begin
      hdr_rdata <= hdr_mem[mem_idx];
    end
  end

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[4:3])
      REG_BASE:   prdata = PDATA_W'(base_address);
      REG_ARENA:  prdata = PDATA_W'(arena_size);
      REG_DALIGN: prdata = PDATA_W'(default_align_log2);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address       <= '0;
      arena_size         <= '0;
      default_align_log2 <= '0;
    end else if (cfg_we) begin
      unique case (paddr[4:3])
        REG_BASE:   base_address       <= pwdata[ADDR_W-1:0];
        REG_ARENA:  arena_size         <= pwdata[SIZE_W-1:0];
        REG_DALIGN: default_align_log2 <= pwdata[ALIGN_W-1:0];
        default:    ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stack_top <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            unique case (in_func)
              FN_ALLOC: begin
                state <= ST_SZ_ADD;
              end
              FN_RESET: begin
                stack_top <= '0;
                state     <= ST_DONE;
              end
              FN_FREE: begin
                state <= (in_blk == '0) ? ST_DONE : ST_OWN_SUB;
              end
              FN_REALLOC: begin
                state <= (in_blk == '0) ? ST_SZ_ADD : ST_OWN_SUB;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_OWN_SUB: state <= ST_OWN_CHK;
        ST_OWN_CHK: begin
          if (blk_ge_base && u_carry && (acc[ADDR_W-1:HDR_SHIFT] != '0)) begin
            state <= ST_OWN_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_OWN_RD: state <= ST_OWN_HDR;
        ST_OWN_HDR: begin
          if (func == FN_FREE || req_size == '0) begin
            stack_top <= hdr_word[HDR_W-1:SIZE_W];
            state     <= ST_DONE;
          end else if (u_carry) begin
            state <= ST_DONE;
          end else begin
            state <= ST_OWN_END;
          end
        end
        ST_OWN_END: state <= ST_OWN_TST;
        ST_OWN_TST: state <= ST_SZ_ADD;
        ST_SZ_ADD:  state <= ST_SZ_RND;
        ST_SZ_RND:  state <= grow ? ST_END : ST_TOP;
        ST_TOP:     state <= ST_ABS;
        ST_ABS:     state <= ST_OFF;
        ST_OFF:     state <= ST_RAD;
        ST_RAD:     state <= ST_END;
        ST_END:     state <= ST_CHK;
        ST_CHK: begin
          if (u_carry) begin
            stack_top <= noff[SIZE_W-1:0];
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      func       <= in_func;
      blk_addr   <= in_blk;
      req_size   <= in_req;
      amask      <= amask_next;
      grow       <= 1'b0;
      move       <= 1'b0;
      res_status <= STS_OK;
      res_addr   <= '0;
      res_size   <= '0;
      res_copy   <= 1'b0;
    end
    if (state == ST_OWN_SUB) begin
      acc         <= u_res;
      blk_ge_base <= u_carry;
    end
    if (state == ST_OWN_CHK) begin
      hdr_off <= OFF_W'(acc[SIZE_W-1:0]) - OFF_W'(HEADER_BYTES);
      if (!(blk_ge_base && u_carry && (acc[ADDR_W-1:HDR_SHIFT] != '0))) begin
        res_status <= STS_NOT_OWNED;
      end
    end
    if (state == ST_OWN_RD) begin
      rd_oor <= !off_in_range;
    end
    if (state == ST_OWN_HDR) begin
      hdr <= hdr_word;
      if (func == FN_FREE || req_size == '0) begin
        res_size <= hdr_word[SIZE_W-1:0];
      end else if (u_carry) begin
        res_addr <= blk_addr;
        res_size <= hdr_word[SIZE_W-1:0];
      end
    end
    if (state == ST_OWN_END || state == ST_TOP || state == ST_ABS || state == ST_RAD) begin
      acc <= u_res;
    end
    if (state == ST_OWN_TST) begin
      grow <= (u_res == '0);
      move <= (u_res != '0);
    end
    if (state == ST_SZ_ADD || state == ST_SZ_RND) begin
      sz <= SZ_W'(u_res);
    end
    if (state == ST_OFF) begin
      hdr_off <= OFF_W'(u_res);
    end
    if (state == ST_END) begin
      noff <= NOFF_W'(u_res);
    end
    if (state == ST_CHK) begin
      if (u_carry) begin
        res_addr <= grow ? blk_addr : acc[ADDR_W-1:0];
        res_size <= usize;
        res_copy <= move;
      end else begin
        res_status <= STS_NO_SPACE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_size   <= res_size;
      out_copy   <= res_copy;
      out_used   <= stack_top;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("input accepted twice without a result");

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion");

  a_not_owned_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == STS_NOT_OWNED) |->
      (out_addr == '0 && out_size == '0 && !out_copy))
    else $error("not_owned result carries data");

  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_copy) |-> (out_status == STS_OK))
    else $error("copy flagged on failed request");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench: stack allocator engine, stream requests and register setup checked by an arena predictor.
module testbench;
  import sae_pkg::*;

  localparam int HDR_ENTRIES  = ARENA_BYTES_DEF / HEADER_BYTES;
  localparam int HDR_IDX_W    = $clog2(HDR_ENTRIES);
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  block;
    logic [SIZE_W-1:0]  req_size;
    logic [ALIGN_W-1:0] align_lg;
  } alloc_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   size;
    logic                copy;
    logic [SIZE_W-1:0]   used;
  } alloc_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  wire                  s_tready;
  // func[1:0], block_address[49:2], request_size[66:50], align_log2[70:67], pad
  logic [S_TDATA_W-1:0] s_tdata = '0;
  wire                  m_tvalid;
  logic                 m_tready = 1'b0;
  // status[1:0], result_address[49:2], result_size[66:50], copy_needed[67],
  // used_bytes[84:68], pad
  wire  [M_TDATA_W-1:0] m_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  wire  [PDATA_W-1:0]   prdata;
  wire                  pready;

  // predictor state
  logic [ADDR_W-1:0]  cfg_base = '0;
  logic [SIZE_W-1:0]  cfg_arena = '0;
  logic [ALIGN_W-1:0] cfg_dalign = '0;
  logic [SIZE_W-1:0]  stack_top = '0;
  logic [HDR_W-1:0]   hdr_mem [HDR_ENTRIES];
  bit                 hdr_written [HDR_ENTRIES];

  logic [ADDR_W-1:0]  live_blocks [$];
  alloc_res_t         results_due [$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int cycle_count = 0;

  stack_allocator_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] align_bytes(logic [ALIGN_W-1:0] lg);
    logic [ALIGN_W-1:0] eff;
    eff = (lg > cfg_dalign) ? lg : cfg_dalign;
    if (eff > MAX_ALIGN_LOG2_DEF) eff = ALIGN_W'(MAX_ALIGN_LOG2_DEF);
    return 64'd1 << eff;
  endfunction

  function automatic logic [63:0] round_up(logic [63:0] x, logic [63:0] a);
    return (x + a - 64'd1) & ~(a - 64'd1);
  endfunction

  function automatic logic [63:0] arena_limit();
    return (cfg_arena > ARENA_BYTES_DEF) ? 64'(ARENA_BYTES_DEF) : 64'(cfg_arena);
  endfunction

  function automatic bit owns(logic [ADDR_W-1:0] blk);
    return 64'(blk) >= 64'(cfg_base) + HEADER_BYTES &&
           64'(blk) <= 64'(cfg_base) + 64'(stack_top);
  endfunction

  function automatic void store_header(logic [63:0] off, logic [HDR_W-1:0] v);
    logic [63:0] idx;
    idx = off >> HDR_SHIFT;
    if (idx < HDR_ENTRIES) begin
      hdr_mem[idx[HDR_IDX_W-1:0]] = v;
      hdr_written[idx[HDR_IDX_W-1:0]] = 1'b1;
    end
  endfunction

  function automatic bit claim_space(input logic [SIZE_W-1:0] req,
                                     input logic [ALIGN_W-1:0] lg,
                                     output logic [ADDR_W-1:0] addr,
                                     output logic [SIZE_W-1:0] usize);
    logic [63:0] a, sz, abs_a, off, noff, us, ua;
    addr = '0;
    usize = '0;
    a = align_bytes(lg);
    sz = round_up(64'(req) + HEADER_BYTES, a);
    abs_a = round_up(64'(cfg_base) + 64'(stack_top), a);
    off = abs_a - 64'(cfg_base);
    noff = off + sz;
    if (noff > arena_limit()) return 1'b0;
    us = sz - HEADER_BYTES;
    ua = abs_a + HEADER_BYTES;
    store_header(off, {stack_top, us[SIZE_W-1:0]});
    stack_top = noff[SIZE_W-1:0];
    addr = ua[ADDR_W-1:0];
    usize = us[SIZE_W-1:0];
    return 1'b1;
  endfunction

  function automatic alloc_res_t compute_alloc_result(alloc_op_t op);
    alloc_res_t r;
    logic [63:0] hoff, sz, noff, us;
    logic [HDR_W-1:0] h;
    logic [SIZE_W-1:0] old;
    r.status = STS_OK;
    r.addr = '0;
    r.size = '0;
    r.copy = 1'b0;
    if (op.func == FN_ALLOC) begin
      if (!claim_space(op.req_size, op.align_lg, r.addr, r.size)) r.status = STS_NO_SPACE;
    end else if (op.func == FN_RESET) begin
      stack_top = '0;
    end else if (op.block == '0) begin
      if (op.func == FN_REALLOC && !claim_space(op.req_size, op.align_lg, r.addr, r.size))
        r.status = STS_NO_SPACE;
    end else if (!owns(op.block)) begin
      r.status = STS_NOT_OWNED;
    end else begin
      hoff = 64'(op.block) - HEADER_BYTES - 64'(cfg_base);
      h = hdr_mem[HDR_IDX_W'(hoff >> HDR_SHIFT)];
      old = h[SIZE_W-1:0];
      if (op.func == FN_FREE || op.req_size == '0) begin
        stack_top = h[HDR_W-1:SIZE_W];
        r.size = old;
      end else if (old >= op.req_size) begin
        r.addr = op.block;
        r.size = old;
      end else if (64'(stack_top) == hoff + 64'(old) + HEADER_BYTES) begin
        // top block grows in place, header size rewritten
        sz = round_up(64'(op.req_size) + HEADER_BYTES, align_bytes(op.align_lg));
        noff = hoff + sz;
        if (noff > arena_limit()) begin
          r.status = STS_NO_SPACE;
        end else begin
          us = sz - HEADER_BYTES;
          stack_top = noff[SIZE_W-1:0];
          store_header(hoff, {h[HDR_W-1:SIZE_W], us[SIZE_W-1:0]});
          r.addr = op.block;
          r.size = us[SIZE_W-1:0];
        end
      end else if (claim_space(op.req_size, op.align_lg, r.addr, r.size)) begin
        r.copy = 1'b1;
      end else begin
        r.status = STS_NO_SPACE;
      end
    end
    r.used = stack_top;
    return r;
  endfunction

  function automatic alloc_op_t make_op(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] block,
                                        logic [SIZE_W-1:0] req, logic [ALIGN_W-1:0] lg);
    alloc_op_t op;
    op.func = func;
    op.block = block;
    op.req_size = req;
    op.align_lg = lg;
    return op;
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return SIZE_W'($urandom_range(64));
    if (p < 82) return SIZE_W'($urandom_range(512, 65));
    if (p < 96) return SIZE_W'($urandom_range(4096, 513));
    if (p < 98) return 17'd65536;
    return SIZE_W'($urandom_range(65536, 4097));
  endfunction

  function automatic logic [ALIGN_W-1:0] random_align();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return ALIGN_W'($urandom_range(3));
    if (p < 85) return ALIGN_W'($urandom_range(8, 4));
    if (p < 97) return ALIGN_W'($urandom_range(12, 9));
    return ALIGN_W'($urandom_range(15, 13));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_block();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55 && live_blocks.size() != 0) return live_blocks[$];
    if (p < 78 && live_blocks.size() != 0)
      return live_blocks[$urandom_range(live_blocks.size() - 1)];
    if (p < 85) return '0;
    if (p < 89) return cfg_base + $urandom_range(7);
    if (p < 93) return cfg_base + stack_top + $urandom_range(64, 1);
    if (p < 96) return ADDR_W'({$urandom, $urandom});
    return cfg_base + HEADER_BYTES + $urandom_range(stack_top);
  endfunction

  function automatic alloc_op_t random_request();
    alloc_op_t op;
    int unsigned p;
    logic [63:0] idx;
    p = $urandom_range(99);
    op.block = ADDR_W'({$urandom, $urandom});
    op.req_size = random_size();
    op.align_lg = random_align();
    if (p < 35) begin
      op.func = FN_ALLOC;
    end else if (p < 57) begin
      op.func = FN_FREE;
      op.block = pick_block();
    end else if (p < 90) begin
      op.func = FN_REALLOC;
      op.block = pick_block();
      if ($urandom_range(9) == 0) op.req_size = '0;
    end else if (p < 92) begin
      op.func = FN_RESET;
    end else begin
      op.func = FUNC_W'($urandom_range(3));
      op.req_size = SIZE_W'($urandom_range(65536));
      op.align_lg = ALIGN_W'($urandom_range(15));
      if ($urandom_range(1) == 0) op.block = pick_block();
    end
    // headers that were never written must not be read
    if ((op.func == FN_FREE || op.func == FN_REALLOC) && op.block != '0 && owns(op.block)) begin
      idx = (64'(op.block) - HEADER_BYTES - 64'(cfg_base)) >> HDR_SHIFT;
      if (!hdr_written[idx[HDR_IDX_W-1:0]])
        op.block = (live_blocks.size() != 0) ? live_blocks[$] : '0;
    end
    return op;
  endfunction

  task automatic send_request(input alloc_op_t op, output alloc_res_t res);
    int i;
    res = compute_alloc_result(op);
    if (res.status == STS_OK && res.addr != '0 && res.addr != op.block)
      live_blocks.push_back(res.addr);
    for (i = live_blocks.size() - 1; i >= 0; i--) begin
      if (!owns(live_blocks[i])) live_blocks.delete(i);
    end
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(20, 2) : 1) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, op.align_lg, op.req_size, op.block, op.func};
    do @(posedge clk); while (s_tready !== 1'b1);
    results_due.push_back(res);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BASE: begin
        cfg_base = val[ADDR_W-1:0];
        live_blocks.delete();
      end
      REG_ARENA:  cfg_arena = val[SIZE_W-1:0];
      REG_DALIGN: cfg_dalign = val[ALIGN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] arena,
                           input logic [ALIGN_W-1:0] dalign);
    wait_idle();
    apb_write(REG_BASE, 64'(base));
    apb_write(REG_ARENA, 64'(arena));
    apb_write(REG_DALIGN, 64'(dalign));
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic test_directed();
    alloc_res_t r, ra, rb, rc, rd, re;
    configure(48'h1000, 17'd65536, 4'd0);
    send_request(make_op(FN_FREE, '0, '0, '0), r);
    send_request(make_op(FN_ALLOC, '0, '0, '0), ra);
    send_request(make_op(FN_ALLOC, '0, 17'd100, 4'd12), rb);
    send_request(make_op(FN_ALLOC, '0, 17'd65536, 4'd0), r);
    send_request(make_op(FN_ALLOC, '0, 17'd40, 4'd15), rc);
    send_request(make_op(FN_ALLOC, '0, 17'd24, 4'd3), rd);
    send_request(make_op(FN_REALLOC, rd.addr, 17'd8, 4'd0), r);
    send_request(make_op(FN_REALLOC, rd.addr, 17'd200, 4'd0), r);
    send_request(make_op(FN_REALLOC, rb.addr, 17'd5000, 4'd2), re);
    send_request(make_op(FN_REALLOC, re.addr, 17'd0, 4'd0), r);
    send_request(make_op(FN_FREE, rd.addr, '0, '0), r);
    send_request(make_op(FN_FREE, 48'h1004, '0, '0), r);
    send_request(make_op(FN_FREE, 48'hFFFF_FFFF_FFFF, '0, '0), r);
    send_request(make_op(FN_REALLOC, rd.addr, 17'd16, 4'd0), r);
    send_request(make_op(FN_REALLOC, '0, 17'd16, 4'd0), r);
    send_request(make_op(FN_RESET, '0, '0, '0), r);
    // stale header: free a block whose header lies inside a newer block
    send_request(make_op(FN_ALLOC, '0, 17'd64, 4'd0), ra);
    send_request(make_op(FN_ALLOC, '0, 17'd8, 4'd0), rb);
    send_request(make_op(FN_FREE, ra.addr, '0, '0), r);
    send_request(make_op(FN_ALLOC, '0, 17'd200, 4'd0), rc);
    send_request(make_op(FN_FREE, rb.addr, '0, '0), r);
    send_request(make_op(FN_REALLOC, rc.addr, 17'd65536, 4'd0), r);
    wait_idle();
  endtask

  task automatic test_address_wrap();
    alloc_res_t r;
    configure(48'hFFFF_FFFF_FFFF, 17'd65536, 4'd0);
    send_request(make_op(FN_RESET, '0, '0, '0), r);
    send_request(make_op(FN_ALLOC, '0, 17'd0, 4'd4), r);
    send_request(make_op(FN_FREE, r.addr, '0, '0), r);
    send_request(make_op(FN_ALLOC, '0, 17'd16, 4'd0), r);
    configure(48'hFFFF_FFFF_FF00, 17'd0, 4'd12);
    send_request(make_op(FN_ALLOC, '0, 17'd1, 4'd0), r);
    send_request(make_op(FN_REALLOC, '0, 17'd8, 4'd0), r);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [ADDR_W-1:0] base,
                                     input logic [SIZE_W-1:0] arena,
                                     input logic [ALIGN_W-1:0] dalign, input int count);
    alloc_res_t r;
    configure(base, arena, dalign);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_request(random_request(), r);
    wait_idle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    alloc_res_t r;
    configure(48'h0000_0040_0000, 17'd16384, 4'd2);
    hold_cycles = 300;
    repeat (24) send_request(random_request(), r);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    alloc_res_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (results_due.size() == 0) begin
        note_mismatch("result with nothing expected", '0, m_tdata[63:0]);
      end else begin
        want = results_due.pop_front();
        if (m_tdata[1:0] !== want.status) note_mismatch("status", want.status, m_tdata[1:0]);
        if (m_tdata[49:2] !== want.addr)
          note_mismatch("result_address", want.addr, m_tdata[49:2]);
        if (m_tdata[66:50] !== want.size)
          note_mismatch("result_size", want.size, m_tdata[66:50]);
        if (m_tdata[67] !== want.copy) note_mismatch("copy_needed", want.copy, m_tdata[67]);
        if (m_tdata[84:68] !== want.used)
          note_mismatch("used_bytes", want.used, m_tdata[84:68]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stack_allocator_engine verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_address_wrap();
    test_random_traffic(0, 0, ADDR_W'({$urandom, $urandom}), 17'd65536, 4'd0, 225);
    test_random_traffic(57, 0, 48'h0, 17'd2048, 4'd3, 225);
    test_random_traffic(0, 57, 48'h0000_7FFF_FFF8, 17'd65536, 4'd12, 225);
    test_random_traffic(15, 15, 48'h1234_5678_9AB5, 17'd8192, 4'd1, 225);
    test_backpressure();
    if (mismatches == 0) begin
      $display("stack_allocator_engine verification clean");
    end else begin
      $display("stack_allocator_engine verification failed");
    end
    $finish;
  end

endmodule

/* stack_allocator_engine.f */
hw/rtl/sae_pkg.sv
hw/rtl/stack_allocator_engine.sv
tb/sv/testbench.sv
